/* rtl/bpc_pkg.sv */
// Package for the bitmap parity checker: word widths, lane split,
// lane and verdict structs, verdict codes. No dependencies.
package bpc_pkg;

    localparam int PIX_W     = 20;
    localparam int LANES     = 4;
    localparam int LANE_W    = PIX_W / LANES;
    localparam int LCW       = $clog2(LANE_W + 1);
    localparam int LIW       = (LANE_W > 1) ? $clog2(LANE_W) : 1;
    localparam int CNT_W     = $clog2(PIX_W + 1);
    localparam int THR_W     = 9;
    localparam int BLACK_W   = 9;
    localparam int TOTAL_W   = 6;
    localparam int POS_W     = 5;

    localparam logic [THR_W-1:0] THR_RESET = 9'd200;

    typedef enum logic [1:0] {
        PIC_CORRECT    = 2'd0,
        PIC_REPAIRABLE = 2'd1,
        PIC_BROKEN     = 2'd2
    } t_pic_state;

    typedef struct packed {
        logic [LCW-1:0] row_cnt;
        logic [LCW-1:0] diff_cnt;
        logic           diff_any;
        logic [LIW-1:0] diff_low;
    } t_lane_res;

    typedef struct packed {
        t_pic_state         state;
        logic [TOTAL_W-1:0] mismatch_total;
        logic [POS_W-1:0]   repair_row;
        logic [POS_W-1:0]   repair_col;
    } t_verdict;

endpackage

/* rtl/bitmap_parity_checker.sv */
// Top level of the bitmap parity checker: input stage, pixel lanes, row
// accumulators, quadrant store, merge and output register. Uses bpc_pkg,
// bpc_lane, bpc_merge and bpc_ram.
//
// Usage: a picture is SIDE+1 words on the input channel (i_in_valid /
// o_in_stall). Words 1..SIDE carry one pixel row and its even-parity bit;
// word SIDE+1 carries the column parity bits. One result word follows on
// the output channel (o_out_valid / i_out_stall) and the block is then
// ready for the next picture with no gap.
// Throughput: one word per cycle while o_in_stall is low; the four pixel
// lanes handle a whole row in one pass, and the quadrant store is one RAM
// read and one write a cycle. A result passes the input stage, accumulate
// stage and merge stage before it reaches the output register.
// Stall: when a result waits in the output register and the receiver
// stalls, the pipeline freezes only once a second result reaches the merge
// stage; o_in_stall then rises.
// Reset (synchronous, active low): empties the pipeline, clears the
// picture accumulators and loads the threshold with 200. The quadrant
// store is not cleared; every entry is written before it is read.
// i_cfg_we writes the threshold; write it only while the block is idle.
module bitmap_parity_checker
    import bpc_pkg::*;
#(
    parameter int SIDE = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [PIX_W-1:0]    i_row_pixels,
    input  logic                i_row_parity,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_picture_state,
    output logic [BLACK_W-1:0]  o_black_count,
    output logic                o_is_reverse,
    output logic                o_is_recursive,
    output logic [TOTAL_W-1:0]  o_mismatch_total,
    output logic [POS_W-1:0]    o_repair_row,
    output logic [POS_W-1:0]    o_repair_column
);

    localparam int HALF = SIDE / 2;
    localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int RW   = $clog2(SIDE + 2);
    localparam int BW   = $clog2(SIDE * PIX_W + 1);
    localparam int CW   = (BW > THR_W) ? BW : THR_W;

    localparam logic [RW-1:0] SIDE_R = RW'(SIDE);
    localparam logic [RW-1:0] HALF_R = RW'(HALF);
    localparam logic [RW-1:0] FULL_R = RW'(2 * HALF);

    logic [PIX_W-1:0] pix_mask;
    logic             adv;
    logic             in_acc;

    // control and accumulators
    logic [THR_W-1:0] r_thr;
    logic [RW-1:0]    r_row_cnt;
    logic             r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic [BW-1:0]    r_black, n_black;
    logic [PIX_W-1:0] r_accum, n_accum;
    logic [RW-1:0]    r_row_mis, n_row_mis;
    logic [RW-1:0]    r_first_bad, n_first_bad;
    logic             r_quad, n_quad;

    // pipeline payload
    logic [PIX_W-1:0] r_a_bits, r_b_bits;
    logic             r_a_par, r_b_par;
    logic             r_a_last, r_b_last;
    logic [RW-1:0]    r_a_row, r_b_row;
    logic [LCW-1:0]   r_b_cnt [LANES];
    logic             r_fwd;
    logic [HALF-1:0]  r_fwd_data;
    t_lane_res        r_c_lanes [LANES];
    logic [BW-1:0]    r_c_black;
    logic [RW-1:0]    r_c_row_mis;
    logic [RW-1:0]    r_c_first_bad;
    logic             r_c_quad;
    t_verdict         r_out_verdict;
    logic [BLACK_W-1:0] r_out_black;
    logic             r_out_reverse;
    logic             r_out_quad;

    t_lane_res        lane_res [LANES];
    logic [PIX_W-1:0] diff;
    logic [CNT_W-1:0] row_sum;
    logic [HALF-1:0]  left, right, upper, ram_rdata;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic             b_commit;
    t_verdict         verdict;

    for (genvar i = 0; i < PIX_W; i++) begin : g_mask
        assign pix_mask[i] = (i < SIDE);
    end

    for (genvar j = 0; j < HALF; j++) begin : g_half
        if (j < PIX_W) begin : g_l
            assign left[j] = r_b_bits[j];
        end else begin : g_lz
            assign left[j] = 1'b0;
        end
        if (j + HALF < PIX_W) begin : g_r
            assign right[j] = r_b_bits[j + HALF];
        end else begin : g_rz
            assign right[j] = 1'b0;
        end
    end

    assign adv        = !(r_c_valid && r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;
    assign b_commit   = adv && r_b_valid;
    assign diff       = (r_accum ^ r_b_bits) & pix_mask;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bpc_lane u_lane (
            .i_row  (r_a_bits[l*LANE_W +: LANE_W]),
            .i_diff (diff[l*LANE_W +: LANE_W]),
            .o_res  (lane_res[l])
        );
    end

    // quadrant store: rows of the upper half, read back for the lower half
    assign ram_we    = b_commit && !r_b_last && (r_b_row < HALF_R);
    assign ram_waddr = AW'(r_b_row);
    assign ram_re    = adv && r_a_valid && !r_a_last && (r_a_row >= HALF_R)
                       && (r_a_row < FULL_R);
    assign ram_raddr = AW'(r_a_row - HALF_R);

    bpc_ram #(
        .WIDTH (HALF),
        .DEPTH (HALF)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (left),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign upper = r_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        row_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            row_sum = row_sum + CNT_W'(r_b_cnt[l]);
        end
    end

    always_comb begin
        n_black     = r_black;
        n_accum     = r_accum;
        n_row_mis   = r_row_mis;
        n_first_bad = r_first_bad;
        n_quad      = r_quad;
        if (b_commit) begin
            if (r_b_last) begin
                n_black     = '0;
                n_accum     = '0;
                n_row_mis   = '0;
                n_first_bad = '0;
                n_quad      = 1'b1;
            end else begin
                n_black = r_black + BW'(row_sum);
                n_accum = r_accum ^ r_b_bits;
                if (row_sum[0] != r_b_par) begin
                    n_row_mis = r_row_mis + RW'(1);
                    if (r_first_bad == '0) begin
                        n_first_bad = r_b_row + RW'(1);
                    end
                end
                if (r_b_row < HALF_R) begin
                    if (left != right) begin
                        n_quad = 1'b0;
                    end
                end else if (r_b_row < FULL_R) begin
                    if (left != right || left != upper) begin
                        n_quad = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_row_cnt   <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_black     <= '0;
            r_accum     <= '0;
            r_row_mis   <= '0;
            r_first_bad <= '0;
            r_quad      <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (in_acc) begin
                r_row_cnt <= (r_row_cnt == SIDE_R) ? '0 : r_row_cnt + RW'(1);
            end
            if (adv) begin
                r_a_valid <= in_acc;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid && r_b_last;
            end
            if (adv && r_c_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_black     <= n_black;
            r_accum     <= n_accum;
            r_row_mis   <= n_row_mis;
            r_first_bad <= n_first_bad;
            r_quad      <= n_quad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_bits <= i_row_pixels & pix_mask;
            r_a_par  <= i_row_parity;
            r_a_last <= (r_row_cnt == SIDE_R);
            r_a_row  <= r_row_cnt;

            r_b_bits <= r_a_bits;
            r_b_par  <= r_a_par;
            r_b_last <= r_a_last;
            r_b_row  <= r_a_row;
            for (int l = 0; l < LANES; l++) begin
                r_b_cnt[l]   <= lane_res[l].row_cnt;
                r_c_lanes[l] <= lane_res[l];
            end
            if (ram_re) begin
                r_fwd      <= ram_we && (ram_waddr == ram_raddr);
                r_fwd_data <= left;
            end

            r_c_black     <= r_black;
            r_c_row_mis   <= r_row_mis;
            r_c_first_bad <= r_first_bad;
            r_c_quad      <= r_quad;

            if (r_c_valid) begin
                r_out_verdict <= verdict;
                r_out_black   <= BLACK_W'(r_c_black);
                r_out_reverse <= (CW'(r_c_black) > CW'(r_thr));
                r_out_quad    <= r_c_quad;
            end
        end
    end

    bpc_merge #(
        .SIDE (SIDE)
    ) u_merge (
        .i_lanes     (r_c_lanes),
        .i_row_mis   (r_c_row_mis),
        .i_first_bad (r_c_first_bad),
        .o_verdict   (verdict)
    );

    assign o_out_valid      = r_out_valid;
    assign o_picture_state  = r_out_verdict.state;
    assign o_black_count    = r_out_black;
    assign o_is_reverse     = r_out_reverse;
    assign o_is_recursive   = r_out_quad;
    assign o_mismatch_total = r_out_verdict.mismatch_total;
    assign o_repair_row     = r_out_verdict.repair_row;
    assign o_repair_column  = r_out_verdict.repair_col;

    a_row_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cnt <= SIDE_R)
        else $error("row counter past picture end");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_commit && r_b_last) |=> (r_black == '0 && r_row_mis == '0 && r_quad))
        else $error("accumulators not cleared after column parity word");

    a_one_result_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_b_valid) |-> !r_b_last)
        else $error("two results in flight");

    a_freeze_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (r_c_valid && r_out_valid))
        else $error("pipeline frozen without a pending result");

    a_no_repair_unless_repairable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_picture_state != PIC_REPAIRABLE)
            |-> (o_repair_row == '0 && o_repair_column == '0))
        else $error("repair position on a picture that is not repairable");

endmodule

/* rtl/bpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module bpc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bpc_lane.sv */
// One pixel lane: popcount of its slice of a row word, plus popcount and
// lowest set bit of its slice of the column parity difference. Uses bpc_pkg.
module bpc_lane
    import bpc_pkg::*;
(
    input  logic [LANE_W-1:0] i_row,
    input  logic [LANE_W-1:0] i_diff,
    output t_lane_res         o_res
);

    always_comb begin
        o_res = '0;
        for (int i = 0; i < LANE_W; i++) begin
            o_res.row_cnt  = o_res.row_cnt + LCW'(i_row[i]);
            o_res.diff_cnt = o_res.diff_cnt + LCW'(i_diff[i]);
        end
        for (int i = LANE_W - 1; i >= 0; i--) begin
            if (i_diff[i]) begin
                o_res.diff_any = 1'b1;
                o_res.diff_low = LIW'(i);
            end
        end
    end

endmodule

/* rtl/bpc_merge.sv */
// Merge of the lane results for the column parity word: mismatch total,
// verdict and repair position. Uses bpc_pkg.
module bpc_merge
    import bpc_pkg::*;
#(
    parameter int SIDE = 20
) (
    input  t_lane_res                     i_lanes [LANES],
    input  logic [$clog2(SIDE + 2)-1:0]   i_row_mis,
    input  logic [$clog2(SIDE + 2)-1:0]   i_first_bad,
    output t_verdict                      o_verdict
);

    localparam int RW = $clog2(SIDE + 2);
    localparam int TW = RW + CNT_W;
    localparam logic [RW-1:0] SIDE_P1 = RW'(SIDE + 1);

    logic [CNT_W-1:0] col_bad;
    logic [POS_W-1:0] first_col;
    logic [TW-1:0]    total;

    always_comb begin
        col_bad   = '0;
        first_col = '0;
        for (int l = 0; l < LANES; l++) begin
            col_bad = col_bad + CNT_W'(i_lanes[l].diff_cnt);
        end
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_lanes[l].diff_any) begin
                first_col = POS_W'(l * LANE_W) + POS_W'(i_lanes[l].diff_low) + POS_W'(1);
            end
        end
        total = TW'(i_row_mis) + TW'(col_bad);

        o_verdict                = '0;
        o_verdict.mismatch_total = TOTAL_W'(total);
        if (col_bad > CNT_W'(1) || i_row_mis > RW'(1)) begin
            o_verdict.state = PIC_BROKEN;
        end else if (col_bad == CNT_W'(1) || i_row_mis == RW'(1)) begin
            o_verdict.state      = PIC_REPAIRABLE;
            o_verdict.repair_row = (i_row_mis != '0) ? POS_W'(i_first_bad) : POS_W'(SIDE_P1);
            o_verdict.repair_col = (col_bad != '0) ? first_col : POS_W'(SIDE_P1);
        end else begin
            o_verdict.state = PIC_CORRECT;
        end
    end

endmodule
